[hw/rtl/convex_hull_graham_scan_macros.svh]
// Assertion macros used by the convex hull top level.
`ifndef CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH
`define CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH
`ifndef ASSERT_OFF
`define CVX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CVX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CVX_ASSERT(lbl, prop, msg)
`define CVX_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/cvx_pkg.sv]
// Package with shared constants and types of the convex hull block.
package cvx_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    CLS_RIGHT = 2'd0,
    CLS_UP    = 2'd1,
    CLS_LEFT  = 2'd2
  } angle_cls_t;
endpackage

[hw/rtl/cvx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cvx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/convex_hull_graham_scan.sv]
// Top level of the convex hull block: point store, angle sort and Graham scan.
//
//  channel | valid       | stall       | payload
//  point   | point_valid | point_stall | point_x, point_y, set_end
//  hull    | hull_valid  | hull_stall  | hull_x, hull_y, hull_last, dropped
//
// A point without set_end is taken whenever the block is in its load state. The
// item marked set_end starts the hull run: a pivot search over all points, an
// insertion sort by angle about the pivot, with a cross product when both points
// lie in the upper class (up to n*(n-1)/2 compares), the scan with a turn test
// per stack check, and the hull points out, each held while the receiver stalls.
// The shared multiplier and the one read port of each RAM set the pace of each
// step. Reset is synchronous; the RAMs need no clearing.
// point_stall stays high from set_end until the last hull point is taken.
module convex_hull_graham_scan #(
  parameter int MAX_POINTS = cvx_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cvx_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         point_valid,
  output logic                         point_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         set_end,
  output logic                         hull_valid,
  input  logic                         hull_stall,
  output logic signed [COORD_BITS-1:0] hull_x,
  output logic signed [COORD_BITS-1:0] hull_y,
  output logic                         hull_last,
  output logic                         dropped
);
  import cvx_pkg::*;
  `include "convex_hull_graham_scan_macros.svh"

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef enum logic [4:0] {
    LOAD, PV_RD, PV_CHK, SO_CUR, SO_CURD, SO_JCHK, SO_BIDX, SO_BPT, SO_CMP,
    SO_M1, SO_M2, SO_CMP2, SC_INIT, SC_P0, SC_P1, SC_P3RD, SC_P3IDX, SC_P3PT,
    SC_P2PT, SC_LOOP, SC_P1IDX, SC_P1PT, SC_M1, SC_M2, SC_TURN, SC_PUSH2,
    SC_PUSH3, OUT_RD, OUT_IDX, OUT_PT, OUT_SEND
  } state_t;

  state_t state;
  logic [CW-1:0] count, n, i, j, k, sd;
  logic ovf;
  logic signed [CB-1:0] best_x, best_y;
  logic signed [CB-1:0] p1x, p1y, p2x, p2y, p3x, p3y;
  logic [IW-1:0] bidx, p1idx, p2idx, p3idx;
  logic signed [DW-1:0] ax, ay, bx, by, d1, d2, d3, d4;
  angle_cls_t ca, cb;
  logic [DW:0] la, lb;
  logic signed [PW-1:0] prod, prod_a;

  logic pts_we, ord_we, stk_we;
  logic [IW-1:0] pts_ra, ord_ra, stk_ra, ord_wa, stk_wa;
  logic [IW-1:0] ord_wd, stk_wd, ord_rd, stk_rd;
  logic [2*CB-1:0] pts_rd;
  logic signed [CB-1:0] rx, ry;
  logic signed [DW-1:0] mul_a, mul_b, rdx, rdy;
  logic dec, less;
  logic in_acc, out_acc;

  function automatic logic signed [DW-1:0] sx(input logic signed [CB-1:0] v);
    return {v[CB-1], v};
  endfunction

  function automatic logic [DW:0] l1(input logic signed [DW-1:0] x,
                                     input logic signed [DW-1:0] y);
    logic [DW-1:0] mx, my;
    mx = x[DW-1] ? DW'(-x) : DW'(x);
    my = y[DW-1] ? DW'(-y) : DW'(y);
    return {1'b0, mx} + {1'b0, my};
  endfunction

  function automatic angle_cls_t cls(input logic signed [DW-1:0] x,
                                     input logic signed [DW-1:0] y);
    if (y > 0) return CLS_UP;
    if (y == 0 && x < 0) return CLS_LEFT;
    return CLS_RIGHT;
  endfunction

  assign in_acc = point_valid && !point_stall;
  assign out_acc = hull_valid && !hull_stall;
  assign point_stall = (state != LOAD);
  assign dropped = ovf;
  assign rx = pts_rd[CB-1:0];
  assign ry = pts_rd[2*CB-1:CB];
  assign rdx = sx(rx) - sx(best_x);
  assign rdy = sx(ry) - sx(best_y);

  cvx_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_pts (
    .clk(clk), .we(pts_we), .waddr(count[IW-1:0]), .wdata({point_y, point_x}),
    .raddr(pts_ra), .rdata(pts_rd)
  );
  cvx_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
    .raddr(ord_ra), .rdata(ord_rd)
  );
  cvx_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .raddr(stk_ra), .rdata(stk_rd)
  );

  always_comb begin
    pts_we = in_acc && (count < MAXC);
    pts_ra = '0;
    ord_ra = '0;
    stk_ra = '0;
    mul_a = ax;
    mul_b = by;
    unique case (state)
      PV_RD, SO_CUR: pts_ra = i[IW-1:0];
      SO_JCHK: ord_ra = j[IW-1:0] - 1'b1;
      SO_BIDX: pts_ra = ord_rd;
      SC_P0: ord_ra = IW'(1);
      SC_P3RD: ord_ra = i[IW-1:0];
      SC_P3IDX: begin
        pts_ra = ord_rd;
        stk_ra = sd[IW-1:0] - 1'b1;
      end
      SC_P3PT: pts_ra = stk_rd;
      SC_LOOP: stk_ra = sd[IW-1:0] - 1'b1;
      SC_P1IDX, OUT_IDX: pts_ra = stk_rd;
      OUT_RD: stk_ra = k[IW-1:0];
      default: ;
    endcase
    unique case (state)
      SO_M2: begin
        mul_a = bx;
        mul_b = ay;
      end
      SC_M1: begin
        mul_a = d1;
        mul_b = d2;
      end
      SC_M2: begin
        mul_a = d3;
        mul_b = d4;
      end
      default: ;
    endcase
  end

  always_comb begin
    dec = 1'b0;
    less = 1'b0;
    if (state == SO_CMP) begin
      if (ca != cb) begin
        dec = 1'b1;
        less = ca < cb;
      end else if (ca != CLS_UP) begin
        dec = 1'b1;
        less = la < lb;
      end
    end else if (state == SO_CMP2) begin
      dec = 1'b1;
      less = (prod_a != prod) ? (prod_a > prod) : (la < lb);
    end
    ord_we = dec || (state == SO_JCHK && j == '0);
    ord_wa = j[IW-1:0];
    ord_wd = (dec && less) ? bidx : i[IW-1:0];
    stk_we = (state == SC_P0) || (state == SC_P1) || (state == SC_PUSH2)
             || (state == SC_PUSH3);
    stk_wa = sd[IW-1:0];
    stk_wd = (state == SC_PUSH2) ? p2idx : (state == SC_PUSH3) ? p3idx : ord_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      count <= '0;
      sd <= '0;
      ovf <= 1'b0;
      hull_valid <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (in_acc) begin
            if (count < MAXC) begin
              count <= count + ONE;
            end else begin
              ovf <= 1'b1;
            end
            if (set_end) begin
              n <= (count < MAXC) ? count + ONE : count;
              i <= '0;
              state <= PV_RD;
            end
          end
        end
        PV_RD: state <= PV_CHK;
        PV_CHK: begin
          if (i == '0 || ry < best_y || (ry == best_y && rx < best_x)) begin
            best_x <= rx;
            best_y <= ry;
          end
          if (i + ONE == n) begin
            i <= '0;
            state <= SO_CUR;
          end else begin
            i <= i + ONE;
            state <= PV_RD;
          end
        end
        SO_CUR: state <= SO_CURD;
        SO_CURD: begin
          ax <= rdx;
          ay <= rdy;
          ca <= cls(rdx, rdy);
          la <= l1(rdx, rdy);
          j <= i;
          state <= SO_JCHK;
        end
        SO_JCHK: begin
          if (j == '0) begin
            if (i + ONE == n) begin
              state <= SC_INIT;
            end else begin
              i <= i + ONE;
              state <= SO_CUR;
            end
          end else begin
            state <= SO_BIDX;
          end
        end
        SO_BIDX: begin
          bidx <= ord_rd;
          state <= SO_BPT;
        end
        SO_BPT: begin
          bx <= rdx;
          by <= rdy;
          cb <= cls(rdx, rdy);
          lb <= l1(rdx, rdy);
          state <= SO_CMP;
        end
        SO_M1: begin
          prod <= mul_a * mul_b;
          state <= SO_M2;
        end
        SO_M2: begin
          prod_a <= prod;
          prod <= mul_a * mul_b;
          state <= SO_CMP2;
        end
        SO_CMP, SO_CMP2: begin
          if (!dec) begin
            state <= SO_M1;
          end else if (less) begin
            j <= j - ONE;
            state <= SO_JCHK;
          end else if (i + ONE == n) begin
            state <= SC_INIT;
          end else begin
            i <= i + ONE;
            state <= SO_CUR;
          end
        end
        SC_INIT: begin
          sd <= '0;
          state <= SC_P0;
        end
        SC_P0: begin
          sd <= ONE;
          k <= '0;
          state <= (n > ONE) ? SC_P1 : OUT_RD;
        end
        SC_P1: begin
          sd <= CW'(2);
          i <= CW'(2);
          state <= (n > CW'(2)) ? SC_P3RD : OUT_RD;
        end
        SC_P3RD: state <= SC_P3IDX;
        SC_P3IDX: begin
          p3idx <= ord_rd;
          state <= SC_P3PT;
        end
        SC_P3PT: begin
          p3x <= rx;
          p3y <= ry;
          p2idx <= stk_rd;
          sd <= sd - ONE;
          state <= SC_P2PT;
        end
        SC_P2PT: begin
          p2x <= rx;
          p2y <= ry;
          state <= SC_LOOP;
        end
        SC_LOOP: state <= (sd == '0) ? SC_PUSH2 : SC_P1IDX;
        SC_P1IDX: begin
          p1idx <= stk_rd;
          state <= SC_P1PT;
        end
        SC_P1PT: begin
          p1x <= rx;
          p1y <= ry;
          d1 <= sx(p2x) - sx(rx);
          d2 <= sx(p3y) - sx(ry);
          d3 <= sx(p3x) - sx(rx);
          d4 <= sx(p2y) - sx(ry);
          state <= SC_M1;
        end
        SC_M1: begin
          prod <= mul_a * mul_b;
          state <= SC_M2;
        end
        SC_M2: begin
          prod_a <= prod;
          prod <= mul_a * mul_b;
          state <= SC_TURN;
        end
        SC_TURN: begin
          if (prod_a >= prod) begin
            state <= SC_PUSH2;
          end else begin
            p2idx <= p1idx;
            p2x <= p1x;
            p2y <= p1y;
            sd <= sd - ONE;
            state <= SC_LOOP;
          end
        end
        SC_PUSH2: begin
          sd <= sd + ONE;
          state <= SC_PUSH3;
        end
        SC_PUSH3: begin
          sd <= sd + ONE;
          if (i + ONE == n) begin
            state <= OUT_RD;
          end else begin
            i <= i + ONE;
            state <= SC_P3RD;
          end
        end
        OUT_RD: state <= OUT_IDX;
        OUT_IDX: state <= OUT_PT;
        OUT_PT: begin
          hull_x <= rx;
          hull_y <= ry;
          hull_last <= (k + ONE == sd);
          hull_valid <= 1'b1;
          state <= OUT_SEND;
        end
        OUT_SEND: begin
          if (out_acc) begin
            hull_valid <= 1'b0;
            if (hull_last) begin
              count <= '0;
              sd <= '0;
              ovf <= 1'b0;
              state <= LOAD;
            end else begin
              k <= k + ONE;
              state <= OUT_RD;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  `CVX_ASSERT(a_no_overlap, !(hull_valid && !point_stall), "hull item while loading")
  `CVX_ASSERT(a_count_cap, count <= MAXC, "point count beyond capacity")
  `CVX_ASSERT(a_stack_cap, (state == LOAD) || (sd <= n), "stack deeper than set")
  `CVX_ASSERT(a_end_clear, out_acc && hull_last |=> !hull_valid && count == '0,
              "set not closed after last hull item")
endmodule
